// File: rtl/core/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Types and fixed constants of the Ricker wavelet sampler.
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int STAGES    = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEAK_FREQ,
        REG_START_TIME,
        REG_TIME_STEP,
        REG_SAMPLE_COUNT
    } cfg_reg_t;

    localparam logic [29:0] PI_Q28    = 30'd843314857;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [25:0] ONE_Q20   = 26'd1048576;

    // Per-request side data that rides along the pipeline
    typedef struct packed {
        logic signed [23:0] t;
        logic               in_range;
        logic               zero;
        logic               neg;
        logic [25:0]        mm;
        logic [5:0]         k;
    } side_t;

endpackage

// File: rtl/core/rws_req_if.sv
// ----------------------------------------------------------------------------
// rws_req_if
// Request channel: sample index with valid/ready.
// ----------------------------------------------------------------------------
interface rws_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

// File: rtl/core/rws_rsp_if.sv
// ----------------------------------------------------------------------------
// rws_rsp_if
// Result channel: sample time, amplitude and window flag with valid/ready.
// ----------------------------------------------------------------------------
interface rws_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_time;
    logic signed [15:0] amplitude;
    logic               in_range;

    modport source (output valid, output sample_time, output amplitude,
                    output in_range, input ready);
    modport sink   (input valid, input sample_time, input amplitude,
                    input in_range, output ready);
endinterface

// File: rtl/core/ricker_wavelet_sampler.sv
// Throughput: one request per clock while rsp.ready does not stall the
// output; 13 register stages, each with its own valid bit, and a stage
// moves whenever the one after it is empty or moving.
// Reset clears all stage valid bits and loads the register defaults; the
// exponent table is constant logic and needs no fill.
// ----------------------------------------------------------------------------
// ricker_wavelet_sampler
// t = start_time + index*time_step, a = (pi*f*t)^2, amp = (1-2a)*exp(-a).
// ----------------------------------------------------------------------------
module ricker_wavelet_sampler #(
    parameter int EXP_TABLE_DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rws_pkg::CFG_W-1:0]    cfg_wdata,
    rws_req_if.sink                      req,
    rws_rsp_if.source                    rsp
);
    import rws_pkg::*;

    localparam int AW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int PW = 20 + AW;

    // exp(-i*ln2/D) by alternating series, Q1.30
    function automatic logic [30:0] exp_entry(input int unsigned i);
        logic [63:0] z;
        logic [63:0] sum;
        logic [63:0] term;
        z = (64'(i) * 64'(LN2_Q30) + 64'(EXP_TABLE_DEPTH / 2))
            / 64'(EXP_TABLE_DEPTH);
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 20; n++)
        begin
            term = ((term * z) >> 30) / 64'(n);
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum[30:0];
    endfunction

    logic [30:0] exp_rom [EXP_TABLE_DEPTH+1];

    for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++)
    begin : g_rom
        assign exp_rom[g] = exp_entry(g);
    end

    // configuration registers
    logic [23:0]        peak_freq_reg;
    logic signed [23:0] start_time_reg;
    logic [19:0]        time_step_reg;
    logic [15:0]        sample_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_freq_reg    <= 24'd65536;
            start_time_reg   <= 24'hF00000;
            time_step_reg    <= 20'd1049;
            sample_count_reg <= 16'd1999;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PEAK_FREQ:    peak_freq_reg    <= cfg_wdata;
                REG_START_TIME:   start_time_reg   <= cfg_wdata;
                REG_TIME_STEP:    time_step_reg    <= cfg_wdata[19:0];
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[15:0];
                default:          ;
            endcase
        end
    end

    // pipeline control
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;

    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || rsp.ready;
        for (int s = STAGES - 2; s >= 0; s--)
            en[s] = !valid_reg[s] || en[s+1];
        valid_next[0] = en[0] ? req.valid : valid_reg[0];
        for (int s = 1; s < STAGES; s++)
            valid_next[s] = en[s] ? valid_reg[s-1] : valid_reg[s];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign req.ready = en[0];

    // datapath registers
    side_t              side_reg  [STAGES];
    side_t              side_next [STAGES];
    logic [35:0]        prod_reg,  prod_next;
    logic [23:0]        tmag_reg,  tmag_next;
    logic [47:0]        u_reg,     u_next;
    logic [22:0]        ft_reg,    ft_next;
    logic [22:0]        x_reg,     x_next;
    logic [24:0]        a_reg,     a_next;
    logic [19:0]        r_reg,     r_next;
    logic [AW-1:0]      j_reg,     j_next;
    logic [19:0]        w_reg,     w_next;
    logic [30:0]        hi_reg,    hi_next;
    logic [30:0]        diff_reg,  diff_next;
    logic [19:0]        wt_reg,    wt_next;
    logic [50:0]        lprod_reg, lprod_next;
    logic [30:0]        hi2_reg,   hi2_next;
    logic [30:0]        e_reg,     e_next;
    logic [21:0]        p_reg,     p_next;
    logic signed [15:0] amp_reg,   amp_next;

    logic signed [37:0] sum_t;
    logic signed [23:0] t_sat;
    logic [48:0]        ft_sum;
    logic [53:0]        x_sum;
    logic [46:0]        a_sum;
    logic [56:0]        y_sum;
    logic [25:0]        twice_a;
    logic [PW-1:0]      pos;
    logic [AW-1:0]      j_inc;
    logic [51:0]        corr_sum;
    logic [30:0]        v;
    logic [57:0]        p_sum;

    always_comb
    begin
        // stage 0: index times step, window check
        side_next[0]          = side_reg[0];
        side_next[0].in_range = req.sample_index < sample_count_reg;
        prod_next             = 36'(req.sample_index) * 36'(time_step_reg);

        // stage 1: add start time, saturate
        side_next[1] = side_reg[0];
        sum_t = {{14{start_time_reg[23]}}, start_time_reg} + {2'b00, prod_reg};
        if (sum_t > 38'sd8388607)
            t_sat = 24'sh7FFFFF;
        else if (sum_t < -38'sd8388608)
            t_sat = 24'sh800000;
        else
            t_sat = sum_t[23:0];
        side_next[1].t = t_sat;
        tmag_next      = t_sat[23] ? (~t_sat + 24'd1) : t_sat;

        // stage 2: f * |t|
        side_next[2] = side_reg[1];
        u_next       = 48'(peak_freq_reg) * 48'(tmag_reg);

        // stage 3: round to Q.20, cap
        side_next[3]      = side_reg[2];
        ft_sum            = 49'(u_reg) + 49'd32768;
        ft_next           = ft_sum[38:16];
        side_next[3].zero = |ft_sum[48:39];

        // stage 4: x = pi * f * |t|
        side_next[4]      = side_reg[3];
        x_sum             = 54'(ft_reg) * 54'(PI_Q28) + 54'd134217728;
        x_next            = x_sum[50:28];
        side_next[4].zero = side_reg[3].zero || (|x_sum[53:51]);

        // stage 5: a = x^2
        side_next[5]      = side_reg[4];
        a_sum             = 47'(x_reg) * 47'(x_reg) + 47'd524288;
        a_next            = a_sum[44:20];
        side_next[5].zero = side_reg[4].zero || (|a_sum[46:45]);

        // stage 6: base-2 reduction, 1 - 2a
        side_next[6]   = side_reg[5];
        y_sum          = 57'(a_reg) * 57'(LOG2E_Q30) + 57'd536870912;
        side_next[6].k = y_sum[55:50];
        r_next         = y_sum[49:30];
        twice_a        = {a_reg, 1'b0};
        side_next[6].neg = twice_a > ONE_Q20;
        side_next[6].mm  = (twice_a > ONE_Q20) ? (twice_a - ONE_Q20)
                                               : (ONE_Q20 - twice_a);

        // stage 7: table position
        side_next[7] = side_reg[6];
        pos          = PW'(r_reg) * PW'(EXP_TABLE_DEPTH);
        j_next       = pos[PW-1:20];
        w_next       = pos[19:0];

        // stage 8: table read
        side_next[8] = side_reg[7];
        j_inc        = j_reg + AW'(1);
        hi_next      = exp_rom[j_reg];
        diff_next    = (exp_rom[j_reg] >= exp_rom[j_inc])
                       ? (exp_rom[j_reg] - exp_rom[j_inc]) : 31'd0;
        wt_next      = w_reg;

        // stage 9: interpolation product
        side_next[9] = side_reg[8];
        lprod_next   = 51'(diff_reg) * 51'(wt_reg);
        hi2_next     = hi_reg;

        // stage 10: interpolate, scale by 2^-k
        side_next[10] = side_reg[9];
        corr_sum      = 52'(lprod_reg) + 52'd524288;
        v             = hi2_reg - corr_sum[50:20];
        e_next        = (side_reg[9].k >= 6'd31) ? 31'd0 : (v >> side_reg[9].k);

        // stage 11: (1 - 2a) * exp(-a)
        side_next[11] = side_reg[10];
        p_sum         = 58'(side_reg[10].mm) * 58'(e_reg) + 58'd34359738368;
        p_next        = p_sum[57:36];

        // stage 12: sign, saturate
        side_next[12] = side_reg[11];
        if (side_reg[11].zero)
            amp_next = 16'sd0;
        else if (side_reg[11].neg)
            amp_next = (p_reg > 22'd32768) ? 16'sh8000 : (16'd0 - p_reg[15:0]);
        else
            amp_next = (p_reg > 22'd32767) ? 16'sh7FFF : p_reg[15:0];
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            if (en[s])
                side_reg[s] <= side_next[s];
        end
        if (en[0])
            prod_reg <= prod_next;
        if (en[1])
            tmag_reg <= tmag_next;
        if (en[2])
            u_reg <= u_next;
        if (en[3])
            ft_reg <= ft_next;
        if (en[4])
            x_reg <= x_next;
        if (en[5])
            a_reg <= a_next;
        if (en[6])
            r_reg <= r_next;
        if (en[7])
        begin
            j_reg <= j_next;
            w_reg <= w_next;
        end
        if (en[8])
        begin
            hi_reg   <= hi_next;
            diff_reg <= diff_next;
            wt_reg   <= wt_next;
        end
        if (en[9])
        begin
            lprod_reg <= lprod_next;
            hi2_reg   <= hi2_next;
        end
        if (en[10])
            e_reg <= e_next;
        if (en[11])
            p_reg <= p_next;
        if (en[12])
            amp_reg <= amp_next;
    end

    assign rsp.valid       = valid_reg[STAGES-1];
    assign rsp.sample_time = side_reg[STAGES-1].t;
    assign rsp.amplitude   = amp_reg;
    assign rsp.in_range    = side_reg[STAGES-1].in_range;

endmodule
